>>> src/scancode_to_ascii_fifo_assert.svh
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo assertion macros
// clocked assertion helpers shared by the block's modules
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`define SCANCODE_TO_ASCII_FIFO_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define S2A_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication outside reset
`define S2A_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/s2a_pkg.sv
// ----------------------------------------------------------------------------
// s2a_pkg
// shared types, key codes and keymap tables of the scancode decoder
// ----------------------------------------------------------------------------
package s2a_pkg;

    // request codes
    localparam logic [1:0] REQ_SCAN  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // set-1 key codes
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;

    // ascii codes used by the ctrl events and the case logic
    localparam logic [6:0] ASC_LOW_A = 7'h61;
    localparam logic [6:0] ASC_LOW_Z = 7'h7A;
    localparam logic [6:0] ASC_UP_A  = 7'h41;
    localparam logic [6:0] ASC_UP_Z  = 7'h5A;
    localparam logic [6:0] ASC_LOW_R = 7'h72;
    localparam logic [6:0] ASC_UP_R  = 7'h52;
    localparam logic [6:0] ASC_LOW_C = 7'h63;
    localparam logic [6:0] ASC_UP_C  = 7'h43;
    localparam logic [6:0] ASC_LOW_D = 7'h64;
    localparam logic [6:0] ASC_UP_D  = 7'h44;

    // result status codes
    typedef enum logic [3:0] {
        ST_NONE       = 4'd0,
        ST_QUEUED     = 4'd1,
        ST_DROPPED    = 4'd2,
        ST_SNAPSHOT   = 4'd3,
        ST_INTERRUPT  = 4'd4,
        ST_EOF_SET    = 4'd5,
        ST_READ_OK    = 4'd6,
        ST_READ_EMPTY = 4'd7,
        ST_EOF_ANSWER = 4'd8
    } status_t;

    // operation handed from the front end to the back end
    typedef enum logic [2:0] {
        K_PASS,
        K_PUSH,
        K_EOFSET,
        K_POP,
        K_QUERY
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        status_t    status;
        logic [6:0] ch;
        logic       ctrl;
    } op_t;

    // unshifted keymap
    localparam logic [6:0] ROM_PLAIN [64] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // shifted keymap
    localparam logic [6:0] ROM_SHIFT [64] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

>>> src/s2a_req_if.sv
// ----------------------------------------------------------------------------
// s2a_req_if
// request channel: request type and scancode with valid/ready
// ----------------------------------------------------------------------------
interface s2a_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] scancode;

    modport source (output valid, output req_type, output scancode, input ready);
    modport sink (input valid, input req_type, input scancode, output ready);
endinterface

>>> src/s2a_rsp_if.sv
// ----------------------------------------------------------------------------
// s2a_rsp_if
// result channel: status, character, fill level and flags with valid/ready
// ----------------------------------------------------------------------------
interface s2a_rsp_if #(
    parameter int CNT_W = 9
);
    logic             valid;
    logic             ready;
    logic [3:0]       status;
    logic [6:0]       char_out;
    logic [CNT_W-1:0] fill_count;
    logic             eof_pending;
    logic             ctrl_held;

    modport source (
        output valid, output status, output char_out, output fill_count,
        output eof_pending, output ctrl_held, input ready
    );
    modport sink (
        input valid, input status, input char_out, input fill_count,
        input eof_pending, input ctrl_held, output ready
    );
endinterface

>>> src/s2a_front.sv
// ----------------------------------------------------------------------------
// s2a_front
// tracks modifier keys, maps scancodes through the keymaps, classifies requests
// ----------------------------------------------------------------------------
module s2a_front (
    input  logic            clk,
    input  logic            rst_n,
    s2a_req_if.sink         req,
    output logic            push_valid,
    input  logic            push_ready,
    output s2a_pkg::op_t    push_op
);

    logic lsh_reg, lsh_next;
    logic rsh_reg, rsh_next;
    logic caps_reg, caps_next;
    logic ctrl_reg, ctrl_next;
    logic alt_reg, alt_next;

    logic       press;
    logic [6:0] code;
    logic [6:0] plain;
    logic [6:0] shifted;
    logic       lower;
    logic       keep_plain;
    logic [6:0] ch;

    assign req.ready  = push_ready;
    assign push_valid = req.valid;

    assign press   = ~req.scancode[7];
    assign code    = req.scancode[6:0];
    assign plain   = s2a_pkg::ROM_PLAIN[code[5:0]];
    assign shifted = s2a_pkg::ROM_SHIFT[code[5:0]];
    assign lower   = (plain >= s2a_pkg::ASC_LOW_A) && (plain <= s2a_pkg::ASC_LOW_Z);

    // caps lock cancels shift on letters whose shifted form is the capital
    assign keep_plain = caps_reg && lower && (shifted >= s2a_pkg::ASC_UP_A)
                        && (shifted <= s2a_pkg::ASC_UP_Z) && (shifted[4:0] == plain[4:0]);

    // modifier update and character mapping
    always_comb
    begin
        lsh_next  = lsh_reg;
        rsh_next  = rsh_reg;
        caps_next = caps_reg;
        ctrl_next = ctrl_reg;
        alt_next  = alt_reg;
        ch        = 7'd0;
        if (req.req_type == s2a_pkg::REQ_SCAN && req.scancode != 8'd0)
        begin
            case (code)
                s2a_pkg::KEY_LSHIFT: lsh_next = press;
                s2a_pkg::KEY_RSHIFT: rsh_next = press;
                s2a_pkg::KEY_CAPS:   caps_next = caps_reg ^ press;
                s2a_pkg::KEY_CTRL:   ctrl_next = press;
                s2a_pkg::KEY_ALT:    alt_next = press;
                default:
                begin
                    if (press && !code[6] && plain != 7'd0)
                    begin
                        if (lsh_reg || rsh_reg)
                            ch = keep_plain ? plain : shifted;
                        else
                            ch = (caps_reg && lower) ? shifted : plain;
                    end
                end
            endcase
        end
    end

    // request classification
    always_comb
    begin
        push_op.kind   = s2a_pkg::K_PASS;
        push_op.status = s2a_pkg::ST_NONE;
        push_op.ch     = ch;
        push_op.ctrl   = ctrl_next;
        case (req.req_type)
            s2a_pkg::REQ_SCAN:
            begin
                if (ch != 7'd0)
                begin
                    if (ctrl_reg && (ch == s2a_pkg::ASC_LOW_R || ch == s2a_pkg::ASC_UP_R))
                        push_op.status = s2a_pkg::ST_SNAPSHOT;
                    else if (ctrl_reg && (ch == s2a_pkg::ASC_LOW_C || ch == s2a_pkg::ASC_UP_C))
                        push_op.status = s2a_pkg::ST_INTERRUPT;
                    else if (ctrl_reg && (ch == s2a_pkg::ASC_LOW_D || ch == s2a_pkg::ASC_UP_D))
                        push_op.kind = s2a_pkg::K_EOFSET;
                    else
                        push_op.kind = s2a_pkg::K_PUSH;
                end
            end
            s2a_pkg::REQ_READ:  push_op.kind = s2a_pkg::K_POP;
            s2a_pkg::REQ_QUERY: push_op.kind = s2a_pkg::K_QUERY;
            default:            push_op.kind = s2a_pkg::K_PASS;
        endcase
    end

    // modifier flags advance on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsh_reg  <= 1'b0;
            rsh_reg  <= 1'b0;
            caps_reg <= 1'b0;
            ctrl_reg <= 1'b0;
            alt_reg  <= 1'b0;
        end
        else if (req.valid && push_ready)
        begin
            lsh_reg  <= lsh_next;
            rsh_reg  <= rsh_next;
            caps_reg <= caps_next;
            ctrl_reg <= ctrl_next;
            alt_reg  <= alt_next;
        end
    end

endmodule

>>> src/s2a_queue.sv
// ----------------------------------------------------------------------------
// s2a_queue
// two-entry operation queue between the front end and the back end
// ----------------------------------------------------------------------------
module s2a_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  s2a_pkg::op_t    push_op,
    output logic            pop_valid,
    input  logic            pop_ready,
    output s2a_pkg::op_t    pop_op
);

    s2a_pkg::op_t slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_op     = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and occupancy update
    always_comb
    begin
        wr_next  = do_push ? ~wr_reg : wr_reg;
        rd_next  = do_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_op;
    end

`include "scancode_to_ascii_fifo_assert.svh"

    `S2A_ASSERT_IMP(a_q_ptr_full, cnt_reg == 2'd2, wr_reg == rd_reg, "queue full with split pointers")
    `S2A_ASSERT_IMP(a_q_ptr_one, cnt_reg == 2'd1, wr_reg != rd_reg, "queue pointers lost an entry")

endmodule

>>> src/s2a_back.sv
// ----------------------------------------------------------------------------
// s2a_back
// character fifo, end-of-file flag and registered result stage
// ----------------------------------------------------------------------------
module s2a_back #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  s2a_pkg::op_t    pop_op,
    s2a_rsp_if.source       rsp
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int PW = $clog2(FIFO_DEPTH);

    logic [6:0] mem [FIFO_DEPTH];

    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          eof_reg, eof_next;

    logic              b_valid_reg;
    s2a_pkg::status_t  b_status_reg, b_status_next;
    logic [6:0]        b_ch_reg, b_ch_next;
    logic              b_rd_reg, b_rd_next;
    logic [CW-1:0]     b_cnt_reg;
    logic              b_eof_reg, b_eof_next;
    logic              b_ctrl_reg;
    logic [6:0]        rd_data_reg;

    logic load;
    logic can_push;
    logic can_pop;
    logic do_write;
    logic do_read;

    assign pop_ready = !b_valid_reg || rsp.ready;
    assign load      = pop_valid && pop_ready;
    assign can_push  = (cnt_reg < CW'(FIFO_DEPTH));
    assign can_pop   = (cnt_reg != '0);
    assign do_write  = load && pop_op.kind == s2a_pkg::K_PUSH && can_push;
    assign do_read   = load && pop_op.kind == s2a_pkg::K_POP && can_pop;

    // execute one operation against the fifo and flag
    always_comb
    begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        cnt_next      = cnt_reg;
        eof_next      = eof_reg;
        b_status_next = pop_op.status;
        b_ch_next     = pop_op.ch;
        b_rd_next     = 1'b0;
        case (pop_op.kind)
            s2a_pkg::K_PUSH:
            begin
                if (can_push)
                begin
                    wp_next       = (wp_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    b_status_next = s2a_pkg::ST_QUEUED;
                end
                else
                    b_status_next = s2a_pkg::ST_DROPPED;
            end
            s2a_pkg::K_EOFSET:
            begin
                eof_next      = 1'b1;
                b_status_next = s2a_pkg::ST_EOF_SET;
            end
            s2a_pkg::K_POP:
            begin
                b_ch_next = 7'd0;
                if (can_pop)
                begin
                    rp_next       = (rp_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                    b_rd_next     = 1'b1;
                    b_status_next = s2a_pkg::ST_READ_OK;
                end
                else
                    b_status_next = s2a_pkg::ST_READ_EMPTY;
            end
            s2a_pkg::K_QUERY:
            begin
                eof_next      = 1'b0;
                b_ch_next     = 7'd0;
                b_status_next = s2a_pkg::ST_EOF_ANSWER;
            end
            default:
            begin
                b_status_next = pop_op.status;
            end
        endcase
        b_eof_next = (pop_op.kind == s2a_pkg::K_QUERY) ? eof_reg : eof_next;
    end

    // fifo control state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            cnt_reg     <= '0;
            eof_reg     <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                wp_reg  <= wp_next;
                rp_reg  <= rp_next;
                cnt_reg <= cnt_next;
                eof_reg <= eof_next;
            end
            if (pop_ready)
                b_valid_reg <= pop_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_status_reg <= b_status_next;
            b_ch_reg     <= b_ch_next;
            b_rd_reg     <= b_rd_next;
            b_cnt_reg    <= cnt_next;
            b_eof_reg    <= b_eof_next;
            b_ctrl_reg   <= pop_op.ctrl;
        end
    end

    // character store, registered read port
    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[wp_reg] <= pop_op.ch;
        if (do_read)
            rd_data_reg <= mem[rp_reg];
    end

    assign rsp.valid       = b_valid_reg;
    assign rsp.status      = b_status_reg;
    assign rsp.char_out    = b_rd_reg ? rd_data_reg : b_ch_reg;
    assign rsp.fill_count  = b_cnt_reg;
    assign rsp.eof_pending = b_eof_reg;
    assign rsp.ctrl_held   = b_ctrl_reg;

`include "scancode_to_ascii_fifo_assert.svh"

    `S2A_ASSERT(a_cnt_bound, cnt_reg <= CW'(FIFO_DEPTH), "fifo count beyond depth")
    `S2A_ASSERT_IMP(a_ptr_match, cnt_reg != '0 && cnt_reg != CW'(FIFO_DEPTH), wp_reg != rp_reg, "fifo pointers disagree with count")
    `S2A_ASSERT_IMP(a_empty_read, b_valid_reg && b_status_reg == s2a_pkg::ST_READ_EMPTY, b_cnt_reg == '0, "empty read reported with characters held")

endmodule

>>> src/scancode_to_ascii_fifo.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo
// set-1 scancode to ascii decoder with character fifo and ctrl events
// ----------------------------------------------------------------------------
// path: a request transaction reaches its result transaction through the
//   op queue and then the result register
// throughput: one request per cycle while rsp.ready holds; the fifo store has
//   one write and one registered read port and each request uses at most one
// reset: asynchronous, clears modifier flags, eof, pointers and counts;
//   the character store is not cleared and needs no sweep
module scancode_to_ascii_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    s2a_req_if.sink     req,
    s2a_rsp_if.source   rsp
);

    logic         push_valid;
    logic         push_ready;
    s2a_pkg::op_t push_op;
    logic         pop_valid;
    logic         pop_ready;
    s2a_pkg::op_t pop_op;

    // decode and classify
    s2a_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    // decoupling queue
    s2a_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // fifo and result stage
    s2a_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .rsp       (rsp)
    );

endmodule
